[design/cbr_pkg.sv]
`timescale 1ns / 1ps
// cbr_pkg: constants, codes and the crc helper of the checked block receiver
// no dependencies

package cbr_pkg;

  // buffer geometry
  localparam int MaxBlock  = 32768;
  localparam int BufAddrW  = $clog2(MaxBlock);
  localparam int PosW      = 18;

  // parse phases
  localparam logic [1:0] PH_HEAD     = 2'd0;
  localparam logic [1:0] PH_HEAD_BAD = 2'd1;
  localparam logic [1:0] PH_LEN      = 2'd2;
  localparam logic [1:0] PH_DATA     = 2'd3;

  // result status codes
  localparam logic [2:0] ST_TAKEN = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_BUSY  = 3'd5;
  localparam logic [2:0] ST_FAIL  = 3'd6;

  // frame types, little-endian ascii
  localparam logic [31:0] TYPE_DATA = 32'h6174_6164;
  localparam logic [31:0] TYPE_STAT = 32'h7461_7473;

  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd10;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  // magic "nt01" by byte position
  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6E;
      2'd1:    c = 8'h74;
      2'd2:    c = 8'h30;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

  // crc-16/arc, one byte, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

[design/cbr_ifs.sv]
`timescale 1ns / 1ps
// cbr_ifs: valid/ready channel interfaces of the checked block receiver
// depends on nothing

interface cbr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] link_byte;
  modport source (output valid, output operation, output link_byte, input ready);
  modport sink (input valid, input operation, input link_byte, output ready);
endinterface

interface cbr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] reply_block;
  logic [7:0]  read_byte;
  modport source (output valid, output status, output reply_block, output read_byte,
                  input ready);
  modport sink (input valid, input status, input reply_block, input read_byte,
                output ready);
endinterface

interface cbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/cbr_buf_ram.sv]
`timescale 1ns / 1ps
// cbr_buf_ram: payload buffer, one write and one read port, registered read
// depends on cbr_pkg

module cbr_buf_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [cbr_pkg::BufAddrW-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [cbr_pkg::BufAddrW-1:0] raddr,
  output logic [7:0]                   rdata
);

  logic [7:0] mem [cbr_pkg::MaxBlock];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

[design/checked_block_receiver_core.sv]
`timescale 1ns / 1ps
// checked_block_receiver_core: frame parser, crc check and block store
// depends on cbr_pkg, cbr_ifs and cbr_buf_ram

// Receiver of a stop-and-wait block link. Every input transfer (a link byte
// or a read request) yields exactly one registered result; a new item can
// be taken every cycle unless a result waits untaken: the parser state is
// held in registers and updated in the accept cycle; the 32 KiB payload
// buffer is a single-port-write, single-port-read memory with a registered
// read that drives read_byte directly. Link bytes arriving while a stored
// block is still unread are refused with a busy status. The buffer needs
// no clearing after reset. max_attempts may be written only while idle.

module checked_block_receiver_core (
  input  logic clk,
  input  logic rst_n,
  cbr_in_if.sink    in_ch,
  cbr_out_if.source out_ch,
  cbr_cfg_if.sink   cfg_ch
);

  localparam logic [cbr_pkg::PosW-1:0] MaxBlockPos = cbr_pkg::PosW'(cbr_pkg::MaxBlock);

  // state registers
  logic [7:0]               max_attempts_r;
  logic [1:0]               phase_r, phase_nxt;
  logic [cbr_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [31:0]              type_r, type_nxt;
  logic [31:0]              block_r, block_nxt;
  logic [31:0]              len_r, len_nxt;
  logic [15:0]              rcrc_r, rcrc_nxt;
  logic [15:0]              crc_r, crc_nxt;
  logic [31:0]              exp_r, exp_nxt;
  logic [7:0]               att_r, att_nxt;
  logic [cbr_pkg::PosW-1:0] slen_r, slen_nxt;
  logic [cbr_pkg::PosW-1:0] rpos_r, rpos_nxt;
  logic                     gave_up_r, gave_up_nxt;

  // output stage
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_block_r;
  logic        out_rd_r;

  logic        acc;
  logic [2:0]  res_st;
  logic [31:0] res_blk;
  logic        res_rd;
  logic        mem_we, mem_re;
  logic        do_finish;
  logic [cbr_pkg::PosW-1:0] pos1;
  logic [7:0]  b;
  logic [7:0]  mem_q;

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign b            = in_ch.link_byte;
  assign pos1         = pos_r + 1'b1;

  // next state and result of one accepted item
  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; type_nxt = type_r; block_nxt = block_r;
    len_nxt = len_r; rcrc_nxt = rcrc_r; crc_nxt = crc_r; exp_nxt = exp_r;
    att_nxt = att_r; slen_nxt = slen_r; rpos_nxt = rpos_r; gave_up_nxt = gave_up_r;
    res_st = cbr_pkg::ST_TAKEN; res_blk = 32'd0; res_rd = 1'b0;
    mem_we = 1'b0; mem_re = 1'b0; do_finish = 1'b0;
    if (acc) begin
      if (in_ch.operation) begin
        if (rpos_r < slen_r && rpos_r < MaxBlockPos) begin
          res_st = cbr_pkg::ST_READ; res_rd = 1'b1; mem_re = 1'b1;
          rpos_nxt = rpos_r + 1'b1;
        end else if (gave_up_r) begin
          res_st = cbr_pkg::ST_FAIL;
        end else begin
          res_st = cbr_pkg::ST_EMPTY;
        end
      end else if (gave_up_r) begin
        res_st = cbr_pkg::ST_FAIL;
      end else if (rpos_r < slen_r) begin
        res_st = cbr_pkg::ST_BUSY;
      end else begin
        case (phase_r)
          cbr_pkg::PH_HEAD, cbr_pkg::PH_HEAD_BAD: begin
            if (pos_r < 4) begin
              if (pos_r == 0) begin
                phase_nxt = cbr_pkg::PH_HEAD; type_nxt = 32'd0; block_nxt = 32'd0;
              end
              if (b != cbr_pkg::magic_char(pos_r[1:0])) phase_nxt = cbr_pkg::PH_HEAD_BAD;
            end else if (pos_r < 8) begin
              type_nxt[8*pos_r[1:0] +: 8] = type_r[8*pos_r[1:0] +: 8] | b;
            end else begin
              block_nxt[8*pos_r[1:0] +: 8] = block_r[8*pos_r[1:0] +: 8] | b;
            end
            pos_nxt = pos1;
            if (pos1 >= 12) begin
              phase_nxt = cbr_pkg::PH_HEAD;
              pos_nxt = '0;
              if (att_r > max_attempts_r) begin
                gave_up_nxt = 1'b1; res_st = cbr_pkg::ST_FAIL;
              end else begin
                if (att_r != 8'hFF) att_nxt = att_r + 1'b1;
                if (phase_r == cbr_pkg::PH_HEAD_BAD) begin
                  res_st = cbr_pkg::ST_BAD; res_blk = exp_r;
                end else if (type_nxt == cbr_pkg::TYPE_DATA) begin
                  phase_nxt = cbr_pkg::PH_LEN;
                  len_nxt = 32'd0; rcrc_nxt = 16'd0; crc_nxt = 16'd0;
                end else if (type_nxt == cbr_pkg::TYPE_STAT) begin
                  res_st = (block_nxt == exp_r - 1'b1) ? cbr_pkg::ST_OK : cbr_pkg::ST_BAD;
                  res_blk = block_nxt;
                end else begin
                  res_st = cbr_pkg::ST_BAD; res_blk = block_nxt;
                end
              end
            end
          end
          cbr_pkg::PH_LEN: begin
            if (pos_r < 4) len_nxt[8*pos_r[1:0] +: 8] = len_r[8*pos_r[1:0] +: 8] | b;
            else rcrc_nxt[8*pos_r[0] +: 8] = rcrc_r[8*pos_r[0] +: 8] | b;
            pos_nxt = pos1;
            if (pos1 >= 6) begin
              pos_nxt = '0;
              if (len_nxt > 32'(cbr_pkg::MaxBlock)) begin
                phase_nxt = cbr_pkg::PH_HEAD;
                res_st = cbr_pkg::ST_BAD; res_blk = block_r;
              end else if (len_nxt == 32'd0) begin
                do_finish = 1'b1;
              end else begin
                phase_nxt = cbr_pkg::PH_DATA;
              end
            end
          end
          default: begin
            mem_we = 1'b1;
            crc_nxt = cbr_pkg::crc_update(crc_r, b);
            pos_nxt = pos1;
            if (32'(pos1) >= len_r) do_finish = 1'b1;
          end
        endcase
        // end of a data frame: check crc and block order
        if (do_finish) begin
          phase_nxt = cbr_pkg::PH_HEAD;
          pos_nxt = '0;
          if (crc_nxt != rcrc_nxt) begin
            res_st = cbr_pkg::ST_BAD; res_blk = block_r;
          end else if (block_r != exp_r) begin
            if (block_r < exp_r) begin
              res_st = cbr_pkg::ST_OK; res_blk = block_r;
            end else begin
              res_st = cbr_pkg::ST_BAD; res_blk = exp_r;
            end
          end else begin
            res_st = cbr_pkg::ST_OK; res_blk = block_r;
            slen_nxt = len_nxt[cbr_pkg::PosW-1:0];
            rpos_nxt = '0;
            exp_nxt = exp_r + 1'b1;
            att_nxt = 8'd0;
          end
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r <= cbr_pkg::MAX_ATTEMPTS_RST;
      phase_r <= cbr_pkg::PH_HEAD; pos_r <= '0; type_r <= '0; block_r <= '0;
      len_r <= '0; rcrc_r <= '0; crc_r <= '0; exp_r <= '0; att_r <= '0;
      slen_r <= '0; rpos_r <= '0; gave_up_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) max_attempts_r <= cfg_ch.data;
      phase_r <= phase_nxt; pos_r <= pos_nxt; type_r <= type_nxt; block_r <= block_nxt;
      len_r <= len_nxt; rcrc_r <= rcrc_nxt; crc_r <= crc_nxt; exp_r <= exp_nxt;
      att_r <= att_nxt; slen_r <= slen_nxt; rpos_r <= rpos_nxt; gave_up_r <= gave_up_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= res_st;
      out_block_r  <= res_blk;
      out_rd_r     <= res_rd;
    end
  end

  cbr_buf_ram u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r[cbr_pkg::BufAddrW-1:0]),
    .wdata (b),
    .re    (mem_re),
    .raddr (rpos_r[cbr_pkg::BufAddrW-1:0]),
    .rdata (mem_q)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.reply_block = out_block_r;
  assign out_ch.read_byte   = out_rd_r ? mem_q : 8'd0;

endmodule

[design/cbr_checker.sv]
`timescale 1ns / 1ps
// cbr_checker: port-level assertions for the checked block receiver
// depends on cbr_pkg and checked_block_receiver_core, bound below

module cbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] reply_block,
  input logic [7:0]  read_byte
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // every input transfer shows a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("missing result");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= cbr_pkg::ST_FAIL) else $error("bad status");

  // read byte only with read data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != cbr_pkg::ST_READ |-> read_byte == 8'd0)
    else $error("stray read byte");

  // block number only in ok or bad replies
  a_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != cbr_pkg::ST_OK && status != cbr_pkg::ST_BAD
    |-> reply_block == 32'd0)
    else $error("stray block number");

endmodule

bind checked_block_receiver_core cbr_checker u_cbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .reply_block (out_ch.reply_block),
  .read_byte   (out_ch.read_byte)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench of checked_block_receiver_core, with its own
// frame parser, crc-16/arc and block store predictor; depends on cbr_pkg and cbr_ifs

module tb;

  localparam int CycleLimit = 4000000;
  localparam int StallLen   = 300;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] reply_block;
    logic [7:0]  read_byte;
  } reply_t;

  localparam logic [7:0] LINK_MAGIC [4] = '{8'h6E, 8'h74, 8'h30, 8'h31};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbr_in_if  in_ch ();
  cbr_out_if out_ch ();
  cbr_cfg_if cfg_ch ();

  checked_block_receiver_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [1:0]  rx_phase;
  int unsigned rx_pos;
  logic [31:0] rx_type;
  logic [31:0] rx_block;
  logic [31:0] rx_len;
  logic [15:0] rx_crc_field;
  logic [15:0] rx_crc_calc;
  logic [31:0] next_block;
  logic [7:0]  tries;
  logic [7:0]  tries_limit;
  logic [7:0]  block_store [int];
  int unsigned store_len;
  int unsigned store_rd;
  logic        link_failed;

  reply_t      expected_replies[$];
  int          errors = 0;
  int          replies_seen = 0;
  int          items_sent = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  int          rx_wait = 0;
  logic        reply_taken = 1'b0;
  logic        stall_on = 1'b0;
  event        stall_go;

  function automatic logic [15:0] crc16_arc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic reply_t mk(logic [2:0] st, logic [31:0] blk, logic [7:0] rb);
    reply_t r;
    r.status = st;
    r.reply_block = blk;
    r.read_byte = rb;
    return r;
  endfunction

  // end of a data frame whose payload is complete
  function automatic reply_t close_block();
    rx_phase = cbr_pkg::PH_HEAD;
    rx_pos = 0;
    if (rx_crc_calc != rx_crc_field) return mk(cbr_pkg::ST_BAD, rx_block, 8'h00);
    if (rx_block != next_block) begin
      if (rx_block < next_block) return mk(cbr_pkg::ST_OK, rx_block, 8'h00);
      return mk(cbr_pkg::ST_BAD, next_block, 8'h00);
    end
    store_len = rx_len;
    store_rd = 0;
    next_block = next_block + 32'd1;
    tries = 8'd0;
    return mk(cbr_pkg::ST_OK, rx_block, 8'h00);
  endfunction

  // end of a 12-byte header
  function automatic reply_t close_header();
    logic was_bad;
    was_bad = (rx_phase == cbr_pkg::PH_HEAD_BAD);
    rx_phase = cbr_pkg::PH_HEAD;
    rx_pos = 0;
    if (tries > tries_limit) begin
      link_failed = 1'b1;
      return mk(cbr_pkg::ST_FAIL, 32'd0, 8'h00);
    end
    if (tries != 8'd255) tries = tries + 8'd1;
    if (was_bad) return mk(cbr_pkg::ST_BAD, next_block, 8'h00);
    if (rx_type == cbr_pkg::TYPE_DATA) begin
      rx_phase = cbr_pkg::PH_LEN;
      rx_len = 0;
      rx_crc_field = 0;
      rx_crc_calc = 0;
      return mk(cbr_pkg::ST_TAKEN, 32'd0, 8'h00);
    end
    if (rx_type == cbr_pkg::TYPE_STAT && rx_block == next_block - 32'd1)
      return mk(cbr_pkg::ST_OK, rx_block, 8'h00);
    return mk(cbr_pkg::ST_BAD, rx_block, 8'h00);
  endfunction

  // one accepted item into the expected reply
  function automatic reply_t receiver_step(logic op, logic [7:0] b);
    int unsigned p;
    p = rx_pos;
    if (op) begin
      if (store_rd < store_len && store_rd < cbr_pkg::MaxBlock) begin
        store_rd++;
        return mk(cbr_pkg::ST_READ, 32'd0, block_store[store_rd - 1]);
      end
      return mk(link_failed ? cbr_pkg::ST_FAIL : cbr_pkg::ST_EMPTY, 32'd0, 8'h00);
    end
    if (link_failed) return mk(cbr_pkg::ST_FAIL, 32'd0, 8'h00);
    if (store_rd < store_len) return mk(cbr_pkg::ST_BUSY, 32'd0, 8'h00);
    if (rx_phase == cbr_pkg::PH_HEAD || rx_phase == cbr_pkg::PH_HEAD_BAD) begin
      if (p < 4) begin
        if (p == 0) begin
          rx_phase = cbr_pkg::PH_HEAD;
          rx_type = 0;
          rx_block = 0;
        end
        if (b != LINK_MAGIC[p]) rx_phase = cbr_pkg::PH_HEAD_BAD;
      end else if (p < 8) begin
        rx_type[8*(p-4) +: 8] = b;
      end else begin
        rx_block[8*((p-8)%4) +: 8] = b;
      end
      rx_pos = p + 1;
      if (rx_pos >= 12) return close_header();
      return mk(cbr_pkg::ST_TAKEN, 32'd0, 8'h00);
    end
    if (rx_phase == cbr_pkg::PH_LEN) begin
      if (p < 4) rx_len[8*p +: 8] = b;
      else rx_crc_field[8*((p-4)%2) +: 8] = b;
      rx_pos = p + 1;
      if (rx_pos < 6) return mk(cbr_pkg::ST_TAKEN, 32'd0, 8'h00);
      rx_pos = 0;
      if (rx_len > cbr_pkg::MaxBlock) begin
        rx_phase = cbr_pkg::PH_HEAD;
        return mk(cbr_pkg::ST_BAD, rx_block, 8'h00);
      end
      if (rx_len == 0) return close_block();
      rx_phase = cbr_pkg::PH_DATA;
      return mk(cbr_pkg::ST_TAKEN, 32'd0, 8'h00);
    end
    // payload bytes
    if (p < cbr_pkg::MaxBlock) block_store[p] = b;
    rx_crc_calc = crc16_arc_byte(rx_crc_calc, b);
    rx_pos = p + 1;
    if (rx_pos >= rx_len) return close_block();
    return mk(cbr_pkg::ST_TAKEN, 32'd0, 8'h00);
  endfunction

  // send one item, predicting its reply at the transfer
  task automatic send_item(logic op, logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.link_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    expected_replies.push_back(receiver_step(op, b));
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk) in_ch.valid <= 1'b0;
  endtask

  // build and send one frame; crc_skew corrupts the carried crc
  task automatic send_frame(logic [31:0] ftype, logic [31:0] blk, int unsigned len,
                            bit magic_ok, logic [15:0] crc_skew, logic [31:0] len_field);
    logic [7:0]  pay[$];
    logic [15:0] c;
    c = 16'h0000;
    for (int i = 0; i < 4; i++)
      send_item(1'b0, magic_ok ? LINK_MAGIC[i] : LINK_MAGIC[i] ^ 8'h01);
    for (int i = 0; i < 4; i++) send_item(1'b0, ftype[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_item(1'b0, blk[8*i +: 8]);
    if (ftype != cbr_pkg::TYPE_DATA || !magic_ok) return;
    for (int i = 0; i < len; i++) begin
      pay.push_back(8'($urandom_range(0, 255)));
      c = crc16_arc_byte(c, pay[i]);
    end
    c = c ^ crc_skew;
    for (int i = 0; i < 4; i++) send_item(1'b0, len_field[8*i +: 8]);
    send_item(1'b0, c[7:0]);
    send_item(1'b0, c[15:8]);
    if (len_field > cbr_pkg::MaxBlock) return;
    foreach (pay[i]) send_item(1'b0, pay[i]);
  endtask

  task automatic data_frame(logic [31:0] blk, int unsigned len, logic [15:0] crc_skew);
    send_frame(cbr_pkg::TYPE_DATA, blk, len, 1'b1, crc_skew, len);
  endtask

  task automatic read_bytes(int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    int guard;
    release_input();
    guard = 0;
    while (expected_replies.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_attempts(logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    tries_limit = v;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // every frame case once
  task automatic test_frame_cases();
    send_item(1'b1, 8'h00);                           // read with nothing stored
    send_frame(cbr_pkg::TYPE_STAT, 32'd0, 0, 1'b1, 0, 0);  // stat at block zero, no wrap
    send_frame(cbr_pkg::TYPE_STAT, 32'hFFFF_FFFF, 0, 1'b1, 0, 0);
    data_frame(32'd0, 5, 16'h0000);
    send_item(1'b0, 8'h6E);                           // busy, block still unread
    read_bytes(6);
    send_frame(cbr_pkg::TYPE_STAT, 32'd0, 0, 1'b1, 0, 0);  // stat of the last block
    send_frame(cbr_pkg::TYPE_STAT, 32'd1, 0, 1'b1, 0, 0);
    send_frame(cbr_pkg::TYPE_DATA, 32'hA5C3_0F81, 0, 1'b0, 0, 0);  // bad magic
    send_frame(32'h5A5A_A5A5, 32'h8000_0001, 0, 1'b1, 0, 0);  // unknown type
    data_frame(32'd1, 4, 16'h8001);                   // crc mismatch
    data_frame(32'd0, 3, 16'h0000);                   // old block
    data_frame(32'hFFFF_FFFE, 2, 16'h0000);           // future block
    send_frame(cbr_pkg::TYPE_DATA, 32'd1, 0, 1'b1, 0, cbr_pkg::MaxBlock + 1);  // too long
    send_frame(cbr_pkg::TYPE_DATA, 32'd1, 0, 1'b1, 0, 32'hFFFF_FFFF);
    data_frame(32'd1, 0, 16'h0000);                   // zero length, accepted
    send_frame(cbr_pkg::TYPE_DATA, 32'd2, 0, 1'b1, 16'h0001, 0);  // zero length, bad crc
    read_bytes(1);
    data_frame(32'd2, 8, 16'h0000);
    read_bytes(8);
  endtask

  // one longer block, sent and read back without gaps
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    data_frame(next_block, 200, 16'h0000);
    read_bytes(201);
    gaps_on = 1'b1;
  endtask

  // random traffic, mostly well-formed exchanges
  task automatic test_random_traffic(int budget);
    int stop;
    int kind;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        data_frame(next_block, $urandom_range(0, 3) == 0 ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 12), 16'h0000);
        if ($urandom_range(0, 7) == 0) send_item(1'b0, 8'($urandom_range(0, 255)));
        read_bytes(store_len - store_rd + $urandom_range(0, 2));
      end else if (kind < 68) begin
        data_frame(next_block, $urandom_range(1, 10), 16'h1 << $urandom_range(0, 15));
      end else if (kind < 74) begin
        data_frame(next_block - $urandom_range(1, 3), $urandom_range(0, 6), 16'h0000);
      end else if (kind < 78) begin
        data_frame(next_block + $urandom_range(1, 5), $urandom_range(0, 6), 16'h0000);
      end else if (kind < 86) begin
        send_frame(cbr_pkg::TYPE_STAT, next_block - $urandom_range(0, 2), 0, 1'b1, 0, 0);
      end else if (kind < 90) begin
        send_frame($urandom(), $urandom(), 0, 1'($urandom_range(0, 1)), 0, 0);
      end else if (kind < 94) begin
        send_frame(cbr_pkg::TYPE_DATA, next_block, 0, 1'b1, 0,
                   cbr_pkg::MaxBlock + $urandom_range(1, 9999));
      end else begin
        repeat ($urandom_range(1, 14))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_stall();
    -> stall_go;
    data_frame(next_block, 20, 16'h0000);
    read_bytes(20);
  endtask

  // with no tolerance, the second unaccepted frame at the latest gives up for good
  task automatic test_give_up();
    send_frame(cbr_pkg::TYPE_STAT, next_block + 7, 0, 1'b1, 0, 0);
    send_frame(cbr_pkg::TYPE_STAT, next_block + 7, 0, 1'b1, 0, 0);
    send_item(1'b0, 8'h6E);
    read_bytes(2);
  endtask

  // long receiver hold-off, counted in cycles
  always begin
    @(stall_go);
    @(negedge clk) stall_on <= 1'b1;
    repeat (StallLen) @(negedge clk);
    stall_on <= 1'b0;
  end

  // output ready, random wait after each transfer
  always @(negedge clk) begin
    int draw;
    if (stall_on) begin
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (reply_taken && gaps_on) begin
      draw = $urandom_range(0, 15);
      out_ch.ready <= (draw == 0);
      rx_wait <= (draw > 0) ? draw - 1 : 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d replies outstanding", $realtime, expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    reply_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t unexpected reply status %0d", $realtime, out_ch.status);
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status) begin
          errors++;
          $display("%0t status exp %0d got %0d", $realtime, want.status, out_ch.status);
        end
        if (out_ch.reply_block !== want.reply_block) begin
          errors++;
          $display("%0t reply_block exp %h got %h", $realtime, want.reply_block,
                   out_ch.reply_block);
        end
        if (out_ch.read_byte !== want.read_byte) begin
          errors++;
          $display("%0t read_byte exp %h got %h", $realtime, want.read_byte, out_ch.read_byte);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.link_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'h00;
    out_ch.ready = 1'b0;
    rx_phase = cbr_pkg::PH_HEAD;
    rx_pos = 0;
    rx_type = 0;
    rx_block = 0;
    rx_len = 0;
    rx_crc_field = 0;
    rx_crc_calc = 0;
    next_block = 0;
    tries = 0;
    tries_limit = cbr_pkg::MAX_ATTEMPTS_RST;
    store_len = 0;
    store_rd = 0;
    link_failed = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    test_frame_cases();
    test_back_to_back();
    write_max_attempts(8'd255);
    test_random_traffic(400);
    write_max_attempts(8'd40);
    test_random_traffic(350);
    test_output_stall();
    write_max_attempts(8'd200);
    test_random_traffic(350);
    write_max_attempts(8'd0);
    test_give_up();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d input items and %0d replies: frame cases, a gapless block,",
             items_sent, replies_seen);
    $display("random frames under several attempt limits, an output stall and the give-up");
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d replies missing", errors, expected_replies.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
